[design/small_matrix_arithmetic_top_assert.svh]
// assertion macros for the small matrix arithmetic block
// included by small_matrix_arithmetic_top.sv; needs no other file
`ifndef SMALL_MATRIX_ARITHMETIC_TOP_ASSERT_SVH
`define SMALL_MATRIX_ARITHMETIC_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// property must hold at every rising clock edge out of reset
`define SMAT_ASSERT(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) else $error(msg);
// condition must never be seen out of reset
`define SMAT_ASSERT_NEVER(lbl, clk_s, rst_n_s, expr, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) !(expr)) else $error(msg);
`else
`define SMAT_ASSERT(lbl, clk_s, rst_n_s, prop, msg)
`define SMAT_ASSERT_NEVER(lbl, clk_s, rst_n_s, expr, msg)
`endif
`endif

[design/smat_pkg.sv]
// shared constants, codes and types of the small matrix arithmetic block
// no dependencies; imported by smat_alu and small_matrix_arithmetic_top
package smat_pkg;

	// fixed field and register widths
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int RC_W       = 3;
	localparam int OP_W       = 3;
	localparam int DIMREG_W   = 4;
	localparam int SCALE_W    = 16;
	localparam int FRAC       = 8;
	localparam int LOAD_CNT_W = 7;

	// operation codes
	localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
	localparam logic [OP_W-1:0] OP_SUB   = 3'd1;
	localparam logic [OP_W-1:0] OP_SCALE = 3'd2;
	localparam logic [OP_W-1:0] OP_MUL   = 3'd3;
	localparam logic [OP_W-1:0] OP_NEG   = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OPERATION   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_A      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_B      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE_B = 3'd7;

	// accumulator modes of the shared unit
	localparam logic [1:0] ALU_MAC = 2'd0;
	localparam logic [1:0] ALU_ADD = 2'd1;
	localparam logic [1:0] ALU_SUB = 2'd2;
	localparam logic [1:0] ALU_NEG = 2'd3;

	// sequencer to arithmetic unit controls
	typedef struct packed {
		logic [1:0] mode;
		logic       use_scale;
		logic       mul_en;
		logic       acc_en;
		logic       first;
		logic       shift;
	} alu_ctl_t;

endpackage

[design/smat_mem.sv]
// single-port-write, single-port-read operand store with registered read data
// no package dependencies; instantiated twice by small_matrix_arithmetic_top
module smat_mem #(
	parameter int DEPTH  = 64,
	parameter int WIDTH  = 16,
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[design/smat_alu.sv]
// shared multiply-accumulate unit: product register, wide accumulator,
// floor shift and saturation; depends on smat_pkg
module smat_alu #(
	parameter int MAX_DIM    = 8,
	parameter int ENTRY_BITS = 16
) (
	input  logic                                clk,
	input  smat_pkg::alu_ctl_t                  ctl,
	input  logic signed [ENTRY_BITS-1:0]        a_data,
	input  logic signed [ENTRY_BITS-1:0]        b_data,
	input  logic signed [smat_pkg::SCALE_W-1:0] scale,
	output logic signed [ENTRY_BITS-1:0]        res
);
	import smat_pkg::*;

	localparam int MB       = (ENTRY_BITS > SCALE_W) ? ENTRY_BITS : SCALE_W;
	localparam int PW       = ENTRY_BITS + MB;
	localparam int ACC_FULL = PW + $clog2(MAX_DIM) + 1;
	localparam int ACC_W    = (ACC_FULL > 64) ? 64 : ACC_FULL;
	localparam int SW       = ACC_W + 1;
	localparam bit SAT_ACC  = (ACC_W >= 63);
	localparam logic signed [64:0] ACC_LIM = 65'sd1 <<< 62;
	localparam logic signed [ACC_W-1:0] RES_MAX =
		ACC_W'((65'sd1 <<< (ENTRY_BITS - 1)) - 65'sd1);
	localparam logic signed [ACC_W-1:0] RES_MIN =
		ACC_W'(-(65'sd1 <<< (ENTRY_BITS - 1)));

	logic signed [MB-1:0]    b_sel;
	logic signed [PW-1:0]    prod_w;
	logic signed [PW-1:0]    prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] acc_d;
	logic signed [ACC_W-1:0] acc_base;
	logic signed [SW-1:0]    sum_w;
	logic signed [ACC_W-1:0] shifted;

	// multiplier: second operand is a B entry or the scale factor
	assign b_sel  = ctl.use_scale ? MB'(scale) : MB'(b_data);
	assign prod_w = a_data * b_sel;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= prod_w;
		end
	end

	// accumulator update; MAC sums are clamped to the accumulator limit on wide entries
	assign acc_base = ctl.first ? '0 : acc_q;
	assign sum_w    = SW'(acc_base) + SW'(prod_q);

	always_comb begin
		acc_d = acc_q;
		unique case (ctl.mode)
			ALU_MAC: begin
				if (SAT_ACC && (sum_w > ACC_LIM)) begin
					acc_d = ACC_W'(ACC_LIM);
				end else if (SAT_ACC && (sum_w < -ACC_LIM)) begin
					acc_d = ACC_W'(-ACC_LIM);
				end else begin
					acc_d = ACC_W'(sum_w);
				end
			end
			ALU_ADD: acc_d = ACC_W'(a_data) + ACC_W'(b_data);
			ALU_SUB: acc_d = ACC_W'(a_data) - ACC_W'(b_data);
			ALU_NEG: acc_d = -ACC_W'(a_data);
			default: acc_d = acc_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.acc_en) begin
			acc_q <= acc_d;
		end
	end

	// floor back to the entry format when shifting, and saturate
	assign shifted = ctl.shift ? (acc_q >>> FRAC) : acc_q;

	always_comb begin
		if (shifted > RES_MAX) begin
			res = ENTRY_BITS'(RES_MAX);
		end else if (shifted < RES_MIN) begin
			res = ENTRY_BITS'(RES_MIN);
		end else begin
			res = ENTRY_BITS'(shifted);
		end
	end

endmodule

[design/small_matrix_arithmetic_top.sv]
// top level of the small matrix arithmetic block: registers, loader, sequencer
// depends on smat_pkg, smat_mem, smat_alu and small_matrix_arithmetic_top_assert.svh
`include "small_matrix_arithmetic_top_assert.svh"

// Entries of A (then of B for add, subtract and multiply) are taken one beat
// per cycle in stored row-major order; in_ready is high only while loading.
// After the last entry the block walks the result with one shared
// multiply-accumulate unit fed by two stores that each give one read a
// cycle. Each result beat passes read, execute and put; scalar multiply
// adds accumulate, and matrix multiply repeats read, execute and accumulate
// per inner-dimension step; put waits while the output stalls. A dimension
// mismatch gives one error beat instead. The output register lets the next
// result, or the first entry of the next run, be taken while a result still
// waits. Registers may be written only while the block is idle.
module small_matrix_arithmetic_top #(
	parameter int MAX_DIM    = 8,
	parameter int ENTRY_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [smat_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [smat_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [ENTRY_BITS-1:0]          entry,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [ENTRY_BITS-1:0]          result,
	output logic [smat_pkg::RC_W-1:0]             row,
	output logic [smat_pkg::RC_W-1:0]             col,
	output logic                                  dim_error,
	output logic                                  last
);
	import smat_pkg::*;

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int NEED_W = 2 * DIM_W;
	localparam int CMP_W  = (LOAD_CNT_W > NEED_W) ? LOAD_CNT_W : NEED_W;
	localparam int LIN_W  = IDX_W + DIM_W + 1;

	// sequencer states
	localparam logic [2:0] S_LOAD = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_EX   = 3'd2;
	localparam logic [2:0] S_AC   = 3'd3;
	localparam logic [2:0] S_PUT  = 3'd4;
	localparam logic [2:0] S_ERR  = 3'd5;

	// configuration registers
	logic [OP_W-1:0]           operation_q;
	logic [DIMREG_W-1:0]       rows_a_q;
	logic [DIMREG_W-1:0]       cols_a_q;
	logic [DIMREG_W-1:0]       rows_b_q;
	logic [DIMREG_W-1:0]       cols_b_q;
	logic signed [SCALE_W-1:0] scale_q;
	logic                      transpose_a_q;
	logic                      transpose_b_q;

	logic [2:0]            state_q;
	logic [LOAD_CNT_W-1:0] load_cnt_q;
	logic                  loading_b_q;
	logic [IDX_W-1:0]      i_q;
	logic [IDX_W-1:0]      j_q;
	logic [IDX_W-1:0]      k_q;

	logic [DIM_W-1:0] sra, sca, srb, scb;
	logic [DIM_W-1:0] ra, ca, rb, cb, rc;
	logic [OP_W-1:0]  op_eff;
	logic             is_binary, is_mac, is_mul, mismatch;

	logic [LOAD_CNT_W-1:0] cnt_inc;
	logic [NEED_W-1:0]     need;
	logic                  phase_done, wr_ok;
	logic                  in_beat, out_free;
	logic                  k_last, j_last, elem_last;

	logic [IDX_W-1:0]  a_col, b_row;
	logic [LIN_W-1:0]  a_lin, b_lin;
	logic              a_we, b_we;
	logic [ENTRY_BITS-1:0] a_rd, b_rd;
	logic signed [ENTRY_BITS-1:0] alu_res;
	alu_ctl_t          ctl;

	logic                  out_valid_q;
	logic [ENTRY_BITS-1:0] result_q;
	logic [RC_W-1:0]       row_q;
	logic [RC_W-1:0]       col_q;
	logic                  err_q;
	logic                  last_q;

	// dimension out of range: zero counts as one, large counts as the maximum
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIMREG_W-1:0] d);
		logic [DIM_W-1:0] r;
		if (d == '0) begin
			r = DIM_W'(1);
		end else if (int'(d) > MAX_DIM) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = DIM_W'(d);
		end
		return r;
	endfunction

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			operation_q   <= OP_ADD;
			rows_a_q      <= DIMREG_W'(1);
			cols_a_q      <= DIMREG_W'(1);
			rows_b_q      <= DIMREG_W'(1);
			cols_b_q      <= DIMREG_W'(1);
			scale_q       <= SCALE_W'(256);
			transpose_a_q <= 1'b0;
			transpose_b_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OPERATION:   operation_q   <= cfg_data[OP_W-1:0];
				REG_ROWS_A:      rows_a_q      <= cfg_data[DIMREG_W-1:0];
				REG_COLS_A:      cols_a_q      <= cfg_data[DIMREG_W-1:0];
				REG_ROWS_B:      rows_b_q      <= cfg_data[DIMREG_W-1:0];
				REG_COLS_B:      cols_b_q      <= cfg_data[DIMREG_W-1:0];
				REG_SCALE:       scale_q       <= cfg_data[SCALE_W-1:0];
				REG_TRANSPOSE_A: transpose_a_q <= cfg_data[0];
				REG_TRANSPOSE_B: transpose_b_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// effective dimensions and operation
	assign sra = clamp_dim(rows_a_q);
	assign sca = clamp_dim(cols_a_q);
	assign srb = clamp_dim(rows_b_q);
	assign scb = clamp_dim(cols_b_q);
	assign ra  = transpose_a_q ? sca : sra;
	assign ca  = transpose_a_q ? sra : sca;
	assign rb  = transpose_b_q ? scb : srb;
	assign cb  = transpose_b_q ? srb : scb;

	assign op_eff    = (operation_q >= OP_NEG) ? OP_NEG : operation_q;
	assign is_mul    = (op_eff == OP_MUL);
	assign is_binary = (op_eff == OP_ADD) || (op_eff == OP_SUB) || is_mul;
	assign is_mac    = (op_eff == OP_SCALE) || is_mul;
	assign mismatch  = (((op_eff == OP_ADD) || (op_eff == OP_SUB)) &&
		((ra != rb) || (ca != cb))) || (is_mul && (ca != rb));
	assign rc        = is_mul ? cb : ca;

	// loader: entry count of the phase in progress
	assign in_ready   = (state_q == S_LOAD);
	assign in_beat    = in_valid && in_ready;
	assign cnt_inc    = load_cnt_q + 1'b1;
	assign need       = loading_b_q ? (NEED_W'(srb) * NEED_W'(scb)) :
		(NEED_W'(sra) * NEED_W'(sca));
	assign phase_done = !(CMP_W'(cnt_inc) < CMP_W'(need));
	assign wr_ok      = (int'(load_cnt_q) < DEPTH);
	assign a_we       = in_beat && !loading_b_q && wr_ok;
	assign b_we       = in_beat && loading_b_q && wr_ok;

	// walk position
	assign k_last    = !is_mul || ((DIM_W'(k_q) + 1'b1) == ca);
	assign j_last    = ((DIM_W'(j_q) + 1'b1) == rc);
	assign elem_last = j_last && ((DIM_W'(i_q) + 1'b1) == ra);
	assign out_free  = !out_valid_q || out_ready;

	// store addresses, transposed operands read stored [col][row]
	assign a_col = is_mul ? k_q : j_q;
	assign b_row = is_mul ? k_q : i_q;
	assign a_lin = transpose_a_q ?
		(LIN_W'(a_col) * LIN_W'(sca) + LIN_W'(i_q)) :
		(LIN_W'(i_q) * LIN_W'(sca) + LIN_W'(a_col));
	assign b_lin = transpose_b_q ?
		(LIN_W'(j_q) * LIN_W'(scb) + LIN_W'(b_row)) :
		(LIN_W'(b_row) * LIN_W'(scb) + LIN_W'(j_q));

	smat_mem #(
		.DEPTH (DEPTH),
		.WIDTH (ENTRY_BITS),
		.ADDR_W(ADDR_W)
	) u_store_a (
		.clk  (clk),
		.we   (a_we),
		.waddr(ADDR_W'(load_cnt_q)),
		.wdata(entry),
		.raddr(a_lin[ADDR_W-1:0]),
		.rdata(a_rd)
	);

	smat_mem #(
		.DEPTH (DEPTH),
		.WIDTH (ENTRY_BITS),
		.ADDR_W(ADDR_W)
	) u_store_b (
		.clk  (clk),
		.we   (b_we),
		.waddr(ADDR_W'(load_cnt_q)),
		.wdata(entry),
		.raddr(b_lin[ADDR_W-1:0]),
		.rdata(b_rd)
	);

	// controls of the shared unit
	always_comb begin
		unique case (op_eff)
			OP_ADD:  ctl.mode = ALU_ADD;
			OP_SUB:  ctl.mode = ALU_SUB;
			OP_NEG:  ctl.mode = ALU_NEG;
			default: ctl.mode = ALU_MAC;
		endcase
		ctl.use_scale = (op_eff == OP_SCALE);
		ctl.mul_en    = (state_q == S_EX) && is_mac;
		ctl.acc_en    = ((state_q == S_EX) && !is_mac) || (state_q == S_AC);
		ctl.first     = (k_q == '0);
		ctl.shift     = is_mac;
	end

	smat_alu #(
		.MAX_DIM   (MAX_DIM),
		.ENTRY_BITS(ENTRY_BITS)
	) u_alu (
		.clk   (clk),
		.ctl   (ctl),
		.a_data(a_rd),
		.b_data(b_rd),
		.scale (scale_q),
		.res   (alu_res)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			load_cnt_q  <= '0;
			loading_b_q <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_beat) begin
						if (!phase_done) begin
							load_cnt_q <= cnt_inc;
						end else begin
							load_cnt_q <= '0;
							if (!loading_b_q && is_binary) begin
								loading_b_q <= 1'b1;
							end else begin
								loading_b_q <= 1'b0;
								i_q         <= '0;
								j_q         <= '0;
								k_q         <= '0;
								state_q     <= mismatch ? S_ERR : S_RD;
							end
						end
					end
				end
				S_RD: begin
					state_q <= S_EX;
				end
				S_EX: begin
					state_q <= is_mac ? S_AC : S_PUT;
				end
				S_AC: begin
					if (k_last) begin
						state_q <= S_PUT;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_PUT: begin
					if (out_free) begin
						k_q <= '0;
						if (elem_last) begin
							state_q <= S_LOAD;
						end else if (j_last) begin
							j_q     <= '0;
							i_q     <= i_q + 1'b1;
							state_q <= S_RD;
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				S_ERR: begin
					if (out_free) begin
						state_q <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (((state_q == S_PUT) || (state_q == S_ERR)) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if ((state_q == S_PUT) && out_free) begin
			result_q <= alu_res;
			row_q    <= RC_W'(i_q);
			col_q    <= RC_W'(j_q);
			err_q    <= 1'b0;
			last_q   <= elem_last;
		end else if ((state_q == S_ERR) && out_free) begin
			result_q <= '0;
			row_q    <= '0;
			col_q    <= '0;
			err_q    <= 1'b1;
			last_q   <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;
	assign row       = row_q;
	assign col       = col_q;
	assign dim_error = err_q;
	assign last      = last_q;

	// checks
	`SMAT_ASSERT(a_err_is_last, clk, arst_n, (out_valid && dim_error) |-> last, "error beat without last")
	`SMAT_ASSERT(a_cnt_idle, clk, arst_n, (state_q != S_LOAD) |-> (load_cnt_q == '0), "load count live during compute")
	`SMAT_ASSERT_NEVER(a_b_phase_busy, clk, arst_n, loading_b_q && (state_q != S_LOAD), "B phase flag during compute")
	`SMAT_ASSERT(a_run_starts, clk, arst_n, (in_beat && phase_done && (loading_b_q || !is_binary)) |=> (state_q != S_LOAD), "final entry did not start the walk")

endmodule
